@@ design/specular_map_mip_downsample_macros.svh @@
// Assertion macros for the specular mip downsampler.
// Included by the top level; no other dependencies.
`ifndef SPECULAR_MAP_MIP_DOWNSAMPLE_MACROS_SVH
`define SPECULAR_MAP_MIP_DOWNSAMPLE_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define SMMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smmd: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define SMMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smmd: next-cycle check failed");

`endif

@@ design/smmd_pkg.sv @@
// Shared types and constants of the specular mip downsampler.
// No dependencies; imported by every module of the block but smmd_ram.
`default_nettype none

package smmd_pkg;

    localparam int CFG_W    = 9;
    localparam int Q_DEPTH  = 2;

    localparam logic [7:0] METAL_MIN   = 8'd230;
    localparam logic [7:0] SUBSURF_MIN = 8'd65;
    localparam logic [7:0] EMIS_NONE   = 8'd255;
    localparam logic [9:0] RECIP3      = 10'd683;
    localparam int         RECIP3_SH   = 11;
    localparam logic [2:0] CNT_NONE    = 3'd0;

    typedef logic [7:0]  t_byte;
    typedef t_byte [3:0] t_byte4;

    typedef struct packed {
        logic [7:0] smoothness_in;
        logic [7:0] reflectance_in;
        logic [7:0] porosity_in;
        logic [7:0] emission_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] smoothness_out;
        logic [7:0] reflectance_out;
        logic [7:0] porosity_out;
        logic [7:0] emission_out;
        logic       last_of_tile;
    } t_pix_out;

    // One 2x2 block: [0] above left, [1] above right, [2] left, [3] current.
    typedef struct packed {
        t_pix_in [3:0] px;
        logic          last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Rounded numerator and divisor of one channel mean.
    typedef struct packed {
        logic [9:0] num;
        logic [2:0] cnt;
    } t_num;

    typedef struct packed {
        t_num [3:0] ch;
        logic       last;
    } t_stage;

endpackage

`default_nettype wire

@@ design/smmd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module smmd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/smmd_front.sv @@
// Front end: takes source pixels, tracks the raster position, keeps the even row
// in the line store and assembles 2x2 blocks. Uses smmd_pkg and smmd_ram.
`default_nettype none

module smmd_front #(
    parameter int MAX_WIDTH = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [smmd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire smmd_pkg::t_pix_in         i_pix,
    input  wire smmd_pkg::t_qstat          i_qstat,
    output smmd_pkg::t_push                o_push
);

    import smmd_pkg::*;

    // The line store holds pixel pairs, so both upper pixels of a block come in one read.
    localparam int LS_DEPTH = (MAX_WIDTH >= 2) ? MAX_WIDTH / 2 : 1;
    localparam int ADDR_W   = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
    localparam int W_CAP    = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam logic [CFG_W-1:0] W_CAP_V = CFG_W'(W_CAP);
    localparam logic [CFG_W-1:0] W_ONE   = CFG_W'(1);

    logic [CFG_W-1:0] r_width, n_width;
    logic [CFG_W-1:0] r_col, n_col;
    logic [CFG_W-1:0] r_row, n_row;
    t_pix_in          r_even_px;
    t_pix_in          r_held;

    logic [CFG_W-1:0]    width;
    logic [CFG_W-1:0]    edge_pos;
    logic [CFG_W:0]      col_inc;
    logic [CFG_W:0]      row_inc;
    logic                last_col;
    logic                last_row;
    logic                is_one;
    logic                accept;
    logic [ADDR_W+CFG_W-1:0] col_ext;
    logic [ADDR_W-1:0]   pair_addr;
    logic                ls_we;
    logic                ls_re;
    logic [63:0]         ls_rdata;

    always_comb begin
        if (r_width == '0) begin
            width = W_ONE;
        end else if (r_width > W_CAP_V) begin
            width = W_CAP_V;
        end else begin
            width = r_width;
        end
    end

    assign is_one   = (width == W_ONE);
    assign edge_pos = {width[CFG_W-1:1], 1'b0} - W_ONE;
    assign col_inc  = {1'b0, r_col} + (CFG_W+1)'(1);
    assign row_inc  = {1'b0, r_row} + (CFG_W+1)'(1);
    assign last_col = (col_inc >= {1'b0, width});
    assign last_row = (row_inc >= {1'b0, width});

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    assign col_ext   = (ADDR_W+CFG_W)'(r_col);
    assign pair_addr = col_ext[ADDR_W:1];

    // Even rows write a pair on the odd column; odd rows prefetch the pair on the
    // even column, so the data is ready when the block's last pixel arrives.
    assign ls_we = accept && !is_one && !r_row[0] && r_col[0];
    assign ls_re = accept && !is_one && r_row[0] && !r_col[0] && !last_col;

    smmd_ram #(
        .WIDTH (64),
        .DEPTH (LS_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (pair_addr),
        .i_wdata ({i_pix, r_even_px}),
        .i_re    (ls_re),
        .i_raddr (pair_addr),
        .o_rdata (ls_rdata)
    );

    always_comb begin
        n_width = r_width;
        n_col   = r_col;
        n_row   = r_row;
        if (i_cfg_we) begin
            n_width = i_cfg_wdata;
            n_col   = '0;
            n_row   = '0;
        end else if (accept) begin
            if (is_one || last_col) begin
                n_col = '0;
                n_row = (is_one || last_row) ? '0 : row_inc[CFG_W-1:0];
            end else begin
                n_col = col_inc[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_W'(256);
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_width <= n_width;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_row[0] && !r_col[0]) begin
            r_even_px <= i_pix;
        end
        if (accept && r_row[0] && !r_col[0]) begin
            r_held <= i_pix;
        end
    end

    always_comb begin
        o_push.valid = accept && (is_one || (r_row[0] && r_col[0]));
        if (is_one) begin
            o_push.job.px   = {i_pix, i_pix, i_pix, i_pix};
            o_push.job.last = 1'b1;
        end else begin
            o_push.job.px[0] = t_pix_in'(ls_rdata[31:0]);
            o_push.job.px[1] = t_pix_in'(ls_rdata[63:32]);
            o_push.job.px[2] = r_held;
            o_push.job.px[3] = i_pix;
            o_push.job.last  = (r_col == edge_pos) && (r_row == edge_pos);
        end
    end

endmodule

`default_nettype wire

@@ design/smmd_queue.sv @@
// Short block queue between the front end and the arithmetic back end.
// Uses smmd_pkg.
`default_nettype none

module smmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire smmd_pkg::t_push i_push,
    input  wire logic            i_pop,
    output smmd_pkg::t_qstat     o_qstat,
    output smmd_pkg::t_job       o_job
);

    import smmd_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    t_job             r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full  = (r_cnt == CNT_FULL);
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push.valid && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_job   = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

@@ design/smmd_back.sv @@
// Back end: two-stage arithmetic over one 2x2 block, class split and rounding
// numerators first, then the division by the sample count. Uses smmd_pkg.
`default_nettype none

module smmd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire smmd_pkg::t_job i_job,
    input  wire logic           i_job_valid,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output smmd_pkg::t_pix_out  o_pix
);

    import smmd_pkg::*;

    // Mean of the larger class; a tie keeps the lower class.
    function automatic t_num split_num(input t_byte4 v, input t_byte thr);
        logic [9:0] hs;
        logic [9:0] ls;
        logic [2:0] hc;
        logic [2:0] lc;
        t_num       r;
        hs = '0;
        ls = '0;
        hc = '0;
        lc = '0;
        for (int i = 0; i < 4; i++) begin
            if (v[i] >= thr) begin
                hs = hs + 10'(v[i]);
                hc = hc + 3'd1;
            end else begin
                ls = ls + 10'(v[i]);
                lc = lc + 3'd1;
            end
        end
        if (hc > lc) begin
            r.num = hs + 10'(hc >> 1);
            r.cnt = hc;
        end else begin
            r.num = ls + 10'(lc >> 1);
            r.cnt = lc;
        end
        return r;
    endfunction

    function automatic t_num emis_num(input t_byte4 v);
        logic [9:0] s;
        logic [2:0] c;
        t_num       r;
        s = '0;
        c = '0;
        for (int i = 0; i < 4; i++) begin
            if (v[i] != EMIS_NONE) begin
                s = s + 10'(v[i]);
                c = c + 3'd1;
            end
        end
        r.num = s + 10'(c >> 1);
        r.cnt = c;
        return r;
    endfunction

    function automatic t_num smooth_num(input t_byte4 v);
        t_num r;
        r.num = 10'(v[0]) + 10'(v[1]) + 10'(v[2]) + 10'(v[3]) + 10'd2;
        r.cnt = 3'd4;
        return r;
    endfunction

    // Division by three is a reciprocal multiply, exact for numerators below 2048.
    function automatic t_byte div_num(input t_num n);
        logic [19:0] prod;
        t_byte       q;
        prod = 20'(n.num) * 20'(RECIP3);
        case (n.cnt)
            CNT_NONE: q = EMIS_NONE;
            3'd1:     q = n.num[7:0];
            3'd2:     q = n.num[8:1];
            3'd3:     q = prod[RECIP3_SH+7:RECIP3_SH];
            3'd4:     q = n.num[9:2];
            default:  q = EMIS_NONE;
        endcase
        return q;
    endfunction

    t_stage   r_s1, n_s1;
    logic     r_s1_valid;
    t_pix_out r_out, n_out;
    logic     r_out_valid;
    logic     out_ready;
    logic     s1_ready;
    t_byte4   sm, rf, po, em;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_pop     = i_job_valid && s1_ready;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sm[i] = i_job.px[i].smoothness_in;
            rf[i] = i_job.px[i].reflectance_in;
            po[i] = i_job.px[i].porosity_in;
            em[i] = i_job.px[i].emission_in;
        end
        n_s1.ch[0] = smooth_num(sm);
        n_s1.ch[1] = split_num(rf, METAL_MIN);
        n_s1.ch[2] = split_num(po, SUBSURF_MIN);
        n_s1.ch[3] = emis_num(em);
        n_s1.last  = i_job.last;
    end

    always_comb begin
        n_out.smoothness_out  = div_num(r_s1.ch[0]);
        n_out.reflectance_out = div_num(r_s1.ch[1]);
        n_out.porosity_out    = div_num(r_s1.ch[2]);
        n_out.emission_out    = div_num(r_s1.ch[3]);
        n_out.last_of_tile    = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_job_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (out_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule

`default_nettype wire

@@ design/specular_map_mip_downsample.sv @@
// Specular tile 2x2 mip downsampler. Takes one source pixel per cycle unless stalled;
// a block result passes through the block queue, stage 1 and the output register.
// Output rate is at most one per cycle, set by the two-stage back end; the front
// stalls only when the two-entry block queue is full.
// Reset (synchronous, active low) clears the position counters, sets the width to
// 256 and empties the queue and pipeline; the line store is not cleared.
`default_nettype none

`include "specular_map_mip_downsample_macros.svh"

module specular_map_mip_downsample #(
    parameter int MAX_WIDTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [smmd_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire smmd_pkg::t_pix_in          i_pix,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output smmd_pkg::t_pix_out              o_pix
);

    import smmd_pkg::*;

    t_push  push;
    t_qstat qstat;
    t_job   q_job;
    logic   pop;

    smmd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pix       (i_pix),
        .i_qstat     (qstat),
        .o_push      (push)
    );

    smmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_job   (q_job)
    );

    smmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_valid (!qstat.empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pix       (o_pix)
    );

    // The front must never offer a block the queue cannot take, and the back must
    // never take from an empty queue.
    `SMMD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push.valid, !qstat.full)
    `SMMD_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, pop, !qstat.empty)
    `SMMD_ASSERT_NEXT(a_fill, i_clk, i_rst_n, push.valid && !pop && qstat.empty, !qstat.empty)
    `SMMD_ASSERT_NEXT(a_drain, i_clk, i_rst_n, pop && !push.valid && qstat.full, !qstat.full)

endmodule

`default_nettype wire
